### rtl/gpf_pkg.sv
// Package for the GF(2) polynomial fingerprint block.
// Holds the word and column types, the queue item and the shared constants.
// No dependencies.
package gpf_pkg;

	localparam int DEGREE = 64;
	localparam int WORD_W = 64;
	localparam int COL_COUNT = 64;
	localparam int CNT_W = $clog2(COL_COUNT);

	localparam logic [WORD_W-1:0] DEGREE_MASK = {WORD_W{1'b1}} >> (WORD_W - DEGREE);
	localparam int TOP_BIT = DEGREE - 1;
	localparam logic [WORD_W-1:0] RESET_POLY = WORD_W'(27);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [COL_COUNT-1:0][WORD_W-1:0] col_arr_t;

	typedef struct packed {
		word_t data_word;
		logic  first_word;
		logic  last_word;
	} item_t;

endpackage

### rtl/gpf_if.sv
// Valid/ready channel interfaces for the fingerprint block.
// Depends on gpf_pkg for the word type.
interface gpf_item_if;
	import gpf_pkg::*;
	logic  valid;
	logic  ready;
	word_t data_word;
	logic  first_word;
	logic  last_word;
	modport source(output valid, data_word, first_word, last_word, input ready);
	modport sink(input valid, data_word, first_word, last_word, output ready);
endinterface

interface gpf_result_if;
	import gpf_pkg::*;
	logic  valid;
	logic  ready;
	word_t fingerprint;
	modport source(output valid, fingerprint, input ready);
	modport sink(input valid, fingerprint, output ready);
endinterface

### rtl/gpf_cols.sv
// Reduction column table and its rebuild sequencer.
// Column i holds x^(DEGREE+i) mod P; depends on gpf_pkg.
module gpf_cols (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  gpf_pkg::word_t   cfg_wr_data,
	output gpf_pkg::col_arr_t cols,
	output logic             busy
);
	import gpf_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            poly_q;
	word_t            cur_q;
	word_t            cur_next;
	col_arr_t         cols_q;

	always_comb begin
		cur_next = (cur_q << 1) & DEGREE_MASK;
		if (cur_q[TOP_BIT]) begin
			cur_next = cur_next ^ poly_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			poly_q <= RESET_POLY & DEGREE_MASK;
			cur_q  <= RESET_POLY & DEGREE_MASK;
		end else if (cfg_wr_en) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			poly_q <= cfg_wr_data & DEGREE_MASK;
			cur_q  <= cfg_wr_data & DEGREE_MASK;
		end else if (busy_q) begin
			cur_q <= cur_next;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(COL_COUNT - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Columns shift down; after a full pass column zero holds the polynomial.
	always_ff @(posedge clk) begin
		if (busy_q && !cfg_wr_en) begin
			cols_q <= {cur_q, cols_q[COL_COUNT-1:1]};
		end
	end

	assign cols = cols_q;
	assign busy = busy_q;

	a_write_starts_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> busy_q && cnt_q == '0)
		else $error("Polynomial write did not restart the column rebuild.");

	a_rebuild_full_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> cnt_q == '0 && $past(cnt_q) == CNT_W'(COL_COUNT - 1))
		else $error("Column rebuild ended before all columns were written.");

endmodule

### rtl/gpf_front.sv
// Front end: accepts input transactions and holds them in a short queue.
// Depends on gpf_pkg and the gpf_item_if interface.
module gpf_front (
	input  logic           clk,
	input  logic           arst_n,
	gpf_item_if.sink       items,
	input  logic           busy,
	output logic           q_valid,
	output gpf_pkg::item_t q_item,
	input  logic           q_pop
);
	import gpf_pkg::*;

	item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	item_t             in_item;

	assign items.ready = !busy && (count_q != QCNT_W'(QDEPTH));
	assign push = items.valid && items.ready;
	assign q_valid = (count_q != '0);
	assign q_item = fifo_q[rd_ptr_q];

	always_comb begin
		in_item.data_word  = items.data_word;
		in_item.first_word = items.first_word;
		in_item.last_word  = items.last_word;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH) && !(q_pop && count_q == '0))
		else $error("Transaction queue overflowed or underflowed.");

endmodule

### rtl/gpf_back.sv
// Back end: folds queued words into the running value and registers results.
// Depends on gpf_pkg, the column table and the gpf_result_if interface.
module gpf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  gpf_pkg::item_t    q_item,
	output logic              q_pop,
	input  gpf_pkg::col_arr_t cols,
	gpf_result_if.source      results
);
	import gpf_pkg::*;

	word_t r_q;
	word_t r_base;
	word_t acc;
	word_t r_next;
	word_t fp_q;
	logic  out_valid_q;
	logic  out_free;

	assign out_free = !out_valid_q || results.ready;
	assign q_pop = q_valid && (!q_item.last_word || out_free);

	always_comb begin
		r_base = q_item.first_word ? '0 : r_q;
		acc = '0;
		for (int i = 0; i < COL_COUNT; i++) begin
			if (r_base[i]) begin
				acc = acc ^ cols[i];
			end
		end
		r_next = acc ^ q_item.data_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				r_q <= q_item.last_word ? '0 : r_next;
			end
			if (q_pop && q_item.last_word) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last_word) begin
			fp_q <= r_next;
		end
	end

	assign results.valid = out_valid_q;
	assign results.fingerprint = fp_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.last_word |=> r_q == '0 && out_valid_q)
		else $error("Last word did not clear the running value or raise a result.");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.last_word |-> !out_valid_q || results.ready)
		else $error("Pending result was overwritten.");

endmodule

### rtl/gf2_polynomial_fingerprint.sv
// Rabin fingerprint over GF(2): each 64-bit word updates the running value to
// (value times x^64 mod P) XOR word, a first flag clears it and a last flag emits it.
// One transaction is taken per clock cycle while the columns are not being rebuilt
// and no result waits on results.ready; that rate is set by the running-value loop,
// a single AND-XOR tree over the 64 reduction columns. A fingerprint passes through
// the queue and the result register before it is offered on results. After reset
// and after every polynomial write, the columns are rebuilt one per cycle while
// items.ready stays low. Depends on gpf_pkg, gpf_if, gpf_cols, gpf_front and gpf_back.
module gf2_polynomial_fingerprint (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  gpf_pkg::word_t cfg_wr_data,
	gpf_item_if.sink       items,
	gpf_result_if.source   results
);
	import gpf_pkg::*;

	col_arr_t cols;
	logic     busy;
	logic     q_valid;
	item_t    q_item;
	logic     q_pop;

	gpf_cols u_cols (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cols        (cols),
		.busy        (busy)
	);

	gpf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.busy    (busy),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	gpf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.cols    (cols),
		.results (results)
	);

endmodule
